### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define PPSC_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ppsc: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define PPSC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppsc: implication violated");

// The consequent holds in the cycle after the antecedent.
`define PPSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppsc: next-cycle implication violated");

`endif

### rtl/core/ppsc_pkg.sv
// ----------------------------------------------------------------------------
// ppsc_pkg
// Shared constants and types of the preemptive priority scheduler core.
// ----------------------------------------------------------------------------
package ppsc_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int TIME_BITS_DEF = 16;
    localparam int PRIO_BITS_DEF = 8;
    localparam int ID_BITS_DEF   = $clog2(MAX_TASKS_DEF + 1);

    // Request operation codes.
    typedef enum logic [0:0] {
        ACT_LOAD = 1'b0,
        ACT_TICK = 1'b1
    } action_t;

endpackage

### rtl/core/ppsc_req_if.sv
// ----------------------------------------------------------------------------
// ppsc_req_if
// Request channel: load a task or advance time by one tick.
// ----------------------------------------------------------------------------
interface ppsc_req_if #(
    parameter int TIME_BITS = ppsc_pkg::TIME_BITS_DEF,
    parameter int PRIO_BITS = ppsc_pkg::PRIO_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    ppsc_pkg::action_t       action;
    logic [TIME_BITS-1:0]    arrival_time;
    logic [TIME_BITS-1:0]    burst_length;
    logic [PRIO_BITS-1:0]    priority_level;

    modport source (
        output valid, action, arrival_time, burst_length, priority_level,
        input  ready
    );

    modport sink (
        input  valid, action, arrival_time, burst_length, priority_level,
        output ready
    );
endinterface

### rtl/core/ppsc_res_if.sv
// ----------------------------------------------------------------------------
// ppsc_res_if
// Result channel: one item per tick request.
// ----------------------------------------------------------------------------
interface ppsc_res_if #(
    parameter int ID_BITS   = ppsc_pkg::ID_BITS_DEF,
    parameter int TIME_BITS = ppsc_pkg::TIME_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [ID_BITS-1:0]      ran_id;
    logic                    segment_start;
    logic                    finished;
    logic [TIME_BITS-1:0]    turnaround;
    logic [TIME_BITS-1:0]    waiting;
    logic                    all_done;

    modport source (
        output valid, ran_id, segment_start, finished, turnaround, waiting, all_done,
        input  ready
    );

    modport sink (
        input  valid, ran_id, segment_start, finished, turnaround, waiting, all_done,
        output ready
    );
endinterface

### rtl/core/ppsc_ram.sv
// ----------------------------------------------------------------------------
// ppsc_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ppsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### rtl/core/preemptive_priority_scheduler_core.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_core
// Preemptive priority scheduler that runs one time unit per tick request.
// A load request appends a task (arrival, burst, priority) to a task RAM; its
// id is its load order plus one, and loads beyond MAX_TASKS are dropped. A
// tick request scans the loaded entries through the RAM's single read port,
// one entry per cycle, picks the arrived, unfinished task with the lowest
// priority value (lowest id on a tie), then writes back its decremented
// remaining time and returns one result. No new request is taken while a
// tick scans or writes back. The result sits in an output register, so new
// requests are taken while it waits; a following tick only stalls in its
// write-back step until the previous result has been taken.
// Time starts at zero and saturates at its maximum, as does the turnaround.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module preemptive_priority_scheduler_core #(
    parameter int MAX_TASKS = ppsc_pkg::MAX_TASKS_DEF,
    parameter int TIME_BITS = ppsc_pkg::TIME_BITS_DEF,
    parameter int PRIO_BITS = ppsc_pkg::PRIO_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ppsc_req_if.sink     req,
    ppsc_res_if.source   res
);
    import ppsc_pkg::*;

    localparam int ID_BITS    = $clog2(MAX_TASKS + 1);
    localparam int ADDR_BITS  = $clog2(MAX_TASKS);
    localparam int ENTRY_BITS = 3 * TIME_BITS + PRIO_BITS;
    localparam int REM_LSB    = 0;
    localparam int PRIO_LSB   = TIME_BITS;
    localparam int BURST_LSB  = TIME_BITS + PRIO_BITS;
    localparam int ARR_LSB    = 2 * TIME_BITS + PRIO_BITS;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } state_t;

    state_t                 state_reg, state_next;
    logic [ID_BITS-1:0]     loaded_count_reg, loaded_count_next;
    logic [ID_BITS-1:0]     finished_count_reg, finished_count_next;
    logic [TIME_BITS-1:0]   current_time_reg, current_time_next;
    logic [ID_BITS-1:0]     previous_id_reg, previous_id_next;
    logic [ID_BITS-1:0]     scan_idx_reg, scan_idx_next;
    logic [ADDR_BITS-1:0]   data_idx_reg, data_idx_next;
    logic                   found_reg, found_next;
    logic [ADDR_BITS-1:0]   best_idx_reg, best_idx_next;
    logic [TIME_BITS-1:0]   best_arr_reg, best_arr_next;
    logic [TIME_BITS-1:0]   best_burst_reg, best_burst_next;
    logic [PRIO_BITS-1:0]   best_prio_reg, best_prio_next;
    logic [TIME_BITS-1:0]   best_rem_reg, best_rem_next;

    logic                   res_valid_reg, res_valid_next;
    logic [ID_BITS-1:0]     res_id_reg, res_id_next;
    logic                   res_seg_reg, res_seg_next;
    logic                   res_fin_reg, res_fin_next;
    logic [TIME_BITS-1:0]   res_turn_reg, res_turn_next;
    logic [TIME_BITS-1:0]   res_wait_reg, res_wait_next;
    logic                   res_all_reg, res_all_next;

    logic                   ram_we;
    logic [ADDR_BITS-1:0]   ram_waddr;
    logic [ENTRY_BITS-1:0]  ram_wdata;
    logic                   ram_re;
    logic [ADDR_BITS-1:0]   ram_raddr;
    logic [ENTRY_BITS-1:0]  ram_rdata;

    logic [TIME_BITS-1:0]   rd_arr, rd_burst, rd_rem;
    logic [PRIO_BITS-1:0]   rd_prio;
    logic                   rd_better;
    logic                   data_last;
    logic                   table_full;
    logic [TIME_BITS-1:0]   rem_dec;
    logic [TIME_BITS:0]     turn_full;
    logic [TIME_BITS-1:0]   turn_sat;
    logic [TIME_BITS-1:0]   wait_val;
    logic                   task_done;
    logic [ID_BITS-1:0]     run_id;
    logic                   update_fire;

    ppsc_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_TASKS)
    ) u_task_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_arr   = ram_rdata[ARR_LSB   +: TIME_BITS];
    assign rd_burst = ram_rdata[BURST_LSB +: TIME_BITS];
    assign rd_prio  = ram_rdata[PRIO_LSB  +: PRIO_BITS];
    assign rd_rem   = ram_rdata[REM_LSB   +: TIME_BITS];

    // Strict compare keeps the earliest id on a priority tie, since the scan ascends.
    assign rd_better = (rd_arr <= current_time_reg) && (rd_rem != '0)
                       && (!found_reg || (rd_prio < best_prio_reg));
    assign data_last  = ((ID_BITS'(data_idx_reg) + ID_BITS'(1)) == loaded_count_reg);
    assign table_full = (loaded_count_reg == ID_BITS'(MAX_TASKS));

    // The chosen task has arrived, so the turnaround is at least one.
    assign rem_dec   = best_rem_reg - TIME_BITS'(1);
    assign turn_full = ({1'b0, current_time_reg} + (TIME_BITS + 1)'(1)) - {1'b0, best_arr_reg};
    assign turn_sat  = turn_full[TIME_BITS] ? TIME_MAX : turn_full[TIME_BITS-1:0];
    assign wait_val  = (turn_sat >= best_burst_reg) ? (turn_sat - best_burst_reg) : '0;
    assign task_done = found_reg && (rem_dec == '0);
    assign run_id    = found_reg ? (ID_BITS'(best_idx_reg) + ID_BITS'(1)) : '0;

    assign update_fire = (state_reg == S_UPDATE) && (!res_valid_reg || res.ready);

    assign req.ready         = (state_reg == S_IDLE);
    assign res.valid         = res_valid_reg;
    assign res.ran_id        = res_id_reg;
    assign res.segment_start = res_seg_reg;
    assign res.finished      = res_fin_reg;
    assign res.turnaround    = res_turn_reg;
    assign res.waiting       = res_wait_reg;
    assign res.all_done      = res_all_reg;

    always_comb
    begin
        state_next          = state_reg;
        loaded_count_next   = loaded_count_reg;
        finished_count_next = finished_count_reg;
        current_time_next   = current_time_reg;
        previous_id_next    = previous_id_reg;
        scan_idx_next       = scan_idx_reg;
        data_idx_next       = data_idx_reg;
        found_next          = found_reg;
        best_idx_next       = best_idx_reg;
        best_arr_next       = best_arr_reg;
        best_burst_next     = best_burst_reg;
        best_prio_next      = best_prio_reg;
        best_rem_next       = best_rem_reg;
        res_valid_next      = res_valid_reg && !res.ready;
        res_id_next         = res_id_reg;
        res_seg_next        = res_seg_reg;
        res_fin_next        = res_fin_reg;
        res_turn_next       = res_turn_reg;
        res_wait_next       = res_wait_reg;
        res_all_next        = res_all_reg;

        ram_we    = 1'b0;
        ram_waddr = best_idx_reg;
        ram_wdata = {best_arr_reg, best_burst_reg, best_prio_reg, rem_dec};
        ram_re    = 1'b0;
        ram_raddr = scan_idx_reg[ADDR_BITS-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.action == ACT_LOAD)
                    begin
                        if (!table_full)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = loaded_count_reg[ADDR_BITS-1:0];
                            ram_wdata = {req.arrival_time, req.burst_length,
                                         req.priority_level, req.burst_length};
                            loaded_count_next = loaded_count_reg + ID_BITS'(1);
                            if (req.burst_length == '0)
                            begin
                                finished_count_next = finished_count_reg + ID_BITS'(1);
                            end
                        end
                    end
                    else
                    begin
                        found_next = 1'b0;
                        if (loaded_count_reg == '0)
                        begin
                            state_next = S_UPDATE;
                        end
                        else
                        begin
                            ram_re        = 1'b1;
                            ram_raddr     = '0;
                            scan_idx_next = ID_BITS'(1);
                            data_idx_next = '0;
                            state_next    = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (rd_better)
                begin
                    found_next      = 1'b1;
                    best_idx_next   = data_idx_reg;
                    best_arr_next   = rd_arr;
                    best_burst_next = rd_burst;
                    best_prio_next  = rd_prio;
                    best_rem_next   = rd_rem;
                end
                if (scan_idx_reg < loaded_count_reg)
                begin
                    ram_re        = 1'b1;
                    scan_idx_next = scan_idx_reg + ID_BITS'(1);
                end
                data_idx_next = data_idx_reg + ADDR_BITS'(1);
                if (data_last)
                begin
                    state_next = S_UPDATE;
                end
            end

            S_UPDATE:
            begin
                if (update_fire)
                begin
                    ram_we = found_reg;
                    if (task_done)
                    begin
                        finished_count_next = finished_count_reg + ID_BITS'(1);
                    end
                    res_valid_next = 1'b1;
                    res_id_next    = run_id;
                    res_seg_next   = (run_id != previous_id_reg);
                    res_fin_next   = task_done;
                    res_turn_next  = task_done ? turn_sat : '0;
                    res_wait_next  = task_done ? wait_val : '0;
                    res_all_next   = (finished_count_next >= loaded_count_reg);
                    previous_id_next = run_id;
                    if (current_time_reg != TIME_MAX)
                    begin
                        current_time_next = current_time_reg + TIME_BITS'(1);
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            loaded_count_reg   <= '0;
            finished_count_reg <= '0;
            current_time_reg   <= '0;
            previous_id_reg    <= '0;
            scan_idx_reg       <= '0;
            data_idx_reg       <= '0;
            found_reg          <= 1'b0;
            best_idx_reg       <= '0;
            best_arr_reg       <= '0;
            best_burst_reg     <= '0;
            best_prio_reg      <= '0;
            best_rem_reg       <= '0;
            res_valid_reg      <= 1'b0;
            res_id_reg         <= '0;
            res_seg_reg        <= 1'b0;
            res_fin_reg        <= 1'b0;
            res_turn_reg       <= '0;
            res_wait_reg       <= '0;
            res_all_reg        <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            loaded_count_reg   <= loaded_count_next;
            finished_count_reg <= finished_count_next;
            current_time_reg   <= current_time_next;
            previous_id_reg    <= previous_id_next;
            scan_idx_reg       <= scan_idx_next;
            data_idx_reg       <= data_idx_next;
            found_reg          <= found_next;
            best_idx_reg       <= best_idx_next;
            best_arr_reg       <= best_arr_next;
            best_burst_reg     <= best_burst_next;
            best_prio_reg      <= best_prio_next;
            best_rem_reg       <= best_rem_next;
            res_valid_reg      <= res_valid_next;
            res_id_reg         <= res_id_next;
            res_seg_reg        <= res_seg_next;
            res_fin_reg        <= res_fin_next;
            res_turn_reg       <= res_turn_next;
            res_wait_reg       <= res_wait_next;
            res_all_reg        <= res_all_next;
        end
    end

    `PPSC_ASSERT(a_fin_le_loaded, finished_count_reg <= loaded_count_reg)
    `PPSC_ASSERT_IMP(a_read_in_range, ram_re, ID_BITS'(ram_raddr) < loaded_count_reg)
    `PPSC_ASSERT_IMP(a_write_state, ram_we, state_reg == S_IDLE || state_reg == S_UPDATE)
    `PPSC_ASSERT_IMP(a_fin_has_id, res_valid_reg && res_fin_reg, res_id_reg != '0)
    `PPSC_ASSERT_NEXT(a_update_result, update_fire, state_reg == S_IDLE && res_valid_reg)

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the preemptive priority scheduler core. A queue of
// load and tick requests feeds a bursty driver, and the receiver stalls on
// patterns of its own, including one long hold-off. A scheduler model updated
// on every accepted request predicts each tick result, and the monitor
// compares every result with the oldest prediction. One phase runs requests
// back to back with no idling on either side.
// ----------------------------------------------------------------------------
module tb;

    import ppsc_pkg::*;

    localparam int TW = TIME_BITS_DEF;
    localparam int PW = PRIO_BITS_DEF;
    localparam int IW = ID_BITS_DEF;
    localparam int NT = MAX_TASKS_DEF;
    localparam int unsigned TIME_TOP = (1 << TW) - 1;
    localparam int NO_TASK = -1;

    localparam int BURSTY_ITEMS   = 900;
    localparam int STEADY_ITEMS   = 100;
    localparam int LATE_ITEMS     = 900;
    localparam int HOLD_AFTER     = 300;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_CAP      = 30;

    typedef struct {
        action_t        action;
        logic [TW-1:0]  arrival;
        logic [TW-1:0]  burst;
        logic [PW-1:0]  prio;
    } sched_req_t;

    typedef struct packed {
        logic [IW-1:0]  ran_id;
        logic           segment_start;
        logic           finished;
        logic [TW-1:0]  turnaround;
        logic [TW-1:0]  waiting;
        logic           all_done;
    } tick_result_t;

    typedef enum {RX_OPEN, RX_COIN, RX_COMB, RX_SPARSE} rx_pattern_t;

    logic clk = 1'b0;
    logic rst_n;

    ppsc_req_if req_ch ();
    ppsc_res_if res_ch ();

    preemptive_priority_scheduler_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Scheduler model state.
    logic [TW-1:0] task_arr   [NT];
    logic [TW-1:0] task_len   [NT];
    logic [TW-1:0] task_rem   [NT];
    logic [PW-1:0] task_prio  [NT];
    int            tasks_held = 0;
    int            tasks_done = 0;
    logic [TW-1:0] sched_now  = '0;
    logic [IW-1:0] last_id    = '0;

    sched_req_t    req_backlog [$];
    tick_result_t  results_due [$];

    bit            req_fire     = 1'b0;
    bit            steady       = 1'b0;
    int            burst_left   = 0;
    int            gap_left     = 0;
    int            hold_left    = 0;
    bit            hold_used    = 1'b0;
    rx_pattern_t   rx_pattern   = RX_OPEN;
    int            rx_left      = 0;
    int            rx_cycle     = 0;
    int            results_seen = 0;
    int            quiet_cycles = 0;
    int            fail_count   = 0;

    function automatic void store_task(input logic [TW-1:0] arr, input logic [TW-1:0] len,
                                       input logic [PW-1:0] prio);
        // A full table drops the load without a trace.
        if (tasks_held < NT)
        begin
            task_arr[tasks_held]  = arr;
            task_len[tasks_held]  = len;
            task_rem[tasks_held]  = len;
            task_prio[tasks_held] = prio;
            if (len == '0)
                tasks_done++;
            tasks_held++;
        end
    endfunction

    function automatic tick_result_t sched_tick();
        int           best;
        int unsigned  span;
        tick_result_t r;
        best = NO_TASK;
        r = '0;
        for (int i = 0; i < tasks_held; i++)
        begin
            if (task_arr[i] <= sched_now && task_rem[i] != '0)
            begin
                if (best == NO_TASK || task_prio[i] < task_prio[best])
                    best = i;
            end
        end
        if (best != NO_TASK)
        begin
            r.ran_id = IW'(best + 1);
            task_rem[best] = task_rem[best] - 1'b1;
            if (task_rem[best] == '0)
            begin
                r.finished = 1'b1;
                tasks_done++;
                span = 32'(sched_now) + 32'd1 - 32'(task_arr[best]);
                if (span > TIME_TOP)
                    span = TIME_TOP;
                r.turnaround = TW'(span);
                // Once time is pinned at the top the turnaround can fall below the burst.
                r.waiting = (span >= 32'(task_len[best])) ? TW'(span - 32'(task_len[best])) : '0;
            end
        end
        r.segment_start = (r.ran_id != last_id);
        r.all_done = (tasks_done >= tasks_held);
        last_id = r.ran_id;
        if (32'(sched_now) < TIME_TOP)
            sched_now = sched_now + 1'b1;
        return r;
    endfunction

    function automatic string fmt_result(input tick_result_t r);
        return $sformatf("id=%0d seg=%0b fin=%0b turn=%0d wait=%0d done=%0b",
                         r.ran_id, r.segment_start, r.finished, r.turnaround, r.waiting,
                         r.all_done);
    endfunction

    function automatic void push_tick();
        sched_req_t item;
        // The task fields of a tick carry noise, which the block must ignore.
        item.action  = ACT_TICK;
        item.arrival = TW'($urandom);
        item.burst   = TW'($urandom);
        item.prio    = PW'($urandom);
        req_backlog.push_back(item);
    endfunction

    function automatic void push_load(input logic [TW-1:0] arr, input logic [TW-1:0] len,
                                      input logic [PW-1:0] prio);
        sched_req_t item;
        item.action  = ACT_LOAD;
        item.arrival = arr;
        item.burst   = len;
        item.prio    = prio;
        req_backlog.push_back(item);
    endfunction

    task automatic settle();
        do
            @(negedge clk);
        while (req_backlog.size() != 0 || results_due.size() != 0);
        @(posedge clk);
    endtask

    always @(negedge clk)
    begin : req_driver
        bit offer;
        offer = 1'b0;
        if (rst_n)
        begin
            if (req_ch.valid && req_fire)
            begin
                req_backlog.delete(0);
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            if (req_ch.valid && !req_fire)
                offer = 1'b1;
            else if (gap_left > 0 && !steady)
                gap_left--;
            else if (req_backlog.size() != 0)
            begin
                offer = 1'b1;
                if (burst_left == 0)
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                             : $urandom_range(1, 30);
            end
            req_ch.valid <= offer;
            if (offer)
            begin
                req_ch.action         <= req_backlog[0].action;
                req_ch.arrival_time   <= req_backlog[0].arrival;
                req_ch.burst_length   <= req_backlog[0].burst;
                req_ch.priority_level <= req_backlog[0].prio;
            end
        end
    end

    always @(negedge clk)
    begin : res_receiver
        bit rdy;
        rdy = 1'b1;
        if (hold_left > 0)
        begin
            hold_left--;
            rdy = 1'b0;
        end
        else if (!hold_used && results_seen >= HOLD_AFTER)
        begin
            // One long hold-off lets the core back up and stall its request side.
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rdy = 1'b0;
        end
        else if (!steady)
        begin
            if (rx_left == 0)
            begin
                rx_pattern = rx_pattern_t'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 160);
            end
            else
                rx_left--;
            rx_cycle++;
            case (rx_pattern)
                RX_OPEN:   rdy = 1'b1;
                RX_COIN:   rdy = ($urandom_range(0, 1) == 1);
                RX_COMB:   rdy = (rx_cycle % 4 == 0);
                RX_SPARSE: rdy = ($urandom_range(0, 7) != 0);
                default:   rdy = 1'b1;
            endcase
        end
        res_ch.ready <= rdy;
    end

    always @(posedge clk)
    begin : monitor
        tick_result_t got;
        tick_result_t want;
        if (rst_n)
        begin
            req_fire <= req_ch.valid && req_ch.ready;
            if (res_ch.valid && res_ch.ready)
            begin
                results_seen++;
                got = {res_ch.ran_id, res_ch.segment_start, res_ch.finished,
                       res_ch.turnaround, res_ch.waiting, res_ch.all_done};
                if (results_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= PRINT_CAP)
                        $display("%0t: unexpected result, expected none, actual %s",
                                 $time, fmt_result(got));
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= PRINT_CAP)
                            $display("%0t: result mismatch, expected %s, actual %s",
                                     $time, fmt_result(want), fmt_result(got));
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                if (req_ch.action == ACT_TICK)
                    results_due.push_back(sched_tick());
                else
                    store_task(req_ch.arrival_time, req_ch.burst_length, req_ch.priority_level);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned gen_time;
        int          first_load;
        int          second_load;
        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.action         = ACT_LOAD;
        req_ch.arrival_time   = '0;
        req_ch.burst_length   = '0;
        req_ch.priority_level = '0;
        res_ch.ready          = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Empty table: idle, all done, and the leading idle segment goes on.
        push_tick();
        // A zero burst finishes on load and never runs.
        push_load('0, '0, '0);
        push_tick();
        // Task 2 arrives at once and needs the longest burst; task 3 arrives only
        // at the very top of time, so it stays waiting for the whole run.
        push_load('0, '1, '1);
        push_load('1, TW'(3), '1);
        push_tick();
        push_tick();
        // Tasks 4 and 5 preempt task 2 and tie on priority.
        push_load(TW'(4), TW'(3), PW'(7));
        push_load(TW'(4), TW'(2), PW'(7));
        repeat (8) push_tick();
        settle();

        // Time still moves here, so arrivals are placed near the running clock.
        gen_time = 32'(sched_now);
        first_load = $urandom_range(0, BURSTY_ITEMS / 2 - 1);
        second_load = $urandom_range(BURSTY_ITEMS / 2, BURSTY_ITEMS - 1);
        for (int n = 0; n < BURSTY_ITEMS; n++)
        begin
            if (n == first_load || n == second_load)
                push_load(TW'(gen_time + $urandom_range(0, 150)), TW'($urandom_range(1, 200)),
                          PW'($urandom_range(0, 255)));
            else
            begin
                push_tick();
                gen_time++;
            end
        end
        settle();

        // Back-to-back ticks with no idling on either side.
        steady = 1'b1;
        repeat (STEADY_ITEMS) push_tick();
        settle();
        steady = 1'b0;

        // Fill the table and keep loading past full.
        gen_time = 32'(sched_now);
        for (int n = 0; n < LATE_ITEMS; n++)
        begin
            if ($urandom_range(0, 29) == 0)
                push_load(TW'(gen_time + $urandom_range(0, 150)),
                          ($urandom_range(0, 9) == 0) ? '0 : TW'($urandom_range(1, 80)),
                          PW'($urandom_range(0, 255)));
            else
            begin
                push_tick();
                gen_time++;
            end
        end
        settle();

        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
